### src/json_string_field_extractor_unit_macros.svh
// ----------------------------------------------------------------------------
// JSON string field extractor assertion macros
// Shared concurrent assertion forms for the extractor checker.
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_FIELD_EXTRACTOR_UNIT_MACROS_SVH
`define JSON_STRING_FIELD_EXTRACTOR_UNIT_MACROS_SVH

// Same-cycle implication, masked while reset is high.
`define JSFE_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("jsfe assertion failed");

// Next-cycle implication, masked while reset is high.
`define JSFE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("jsfe assertion failed");

// Next-cycle implication that is also checked through reset.
`define JSFE_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("jsfe assertion failed");

`endif

### src/jsfe_pkg.sv
// ----------------------------------------------------------------------------
// JSON string field extractor package
// Result types, status codes and the key byte table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package jsfe_pkg;

  localparam int unsigned RES_DEPTH = 4;
  localparam int unsigned RES_PTR_W = $clog2(RES_DEPTH);
  localparam int unsigned RES_CNT_W = $clog2(RES_DEPTH + 1);
  localparam int unsigned KEY_LEN   = 9;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOKEY   = 2'd1;
  localparam logic [1:0] ST_NOQUOTE = 2'd2;
  localparam logic [1:0] ST_TRUNC   = 2'd3;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_U      = 8'h75;

  typedef struct packed {
    logic       is_status;
    logic [7:0] char_out;
    logic [1:0] status_code;
    logic       last_of_run;
  } result_t;

  typedef struct packed {
    logic [1:0]       cnt;
    result_t [1:0]    res;
  } step_out_t;

  function automatic logic [7:0] key_byte(input logic [3:0] idx);
    logic [7:0] b;
    unique case (idx)
      4'd0:    b = CH_QUOTE;
      4'd1:    b = 8'h63;
      4'd2:    b = 8'h6F;
      4'd3:    b = 8'h6E;
      4'd4:    b = 8'h74;
      4'd5:    b = 8'h65;
      4'd6:    b = 8'h6E;
      4'd7:    b = 8'h74;
      4'd8:    b = CH_QUOTE;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic result_t mk_res(input logic st, input logic [7:0] ch,
                                     input logic [1:0] code);
    result_t r;
    r.is_status   = st;
    r.char_out    = ch;
    r.status_code = code;
    r.last_of_run = 1'b0;
    return r;
  endfunction

endpackage

### src/jsfe_parser.sv
// ----------------------------------------------------------------------------
// JSON string field extractor parser
// Holds the parse state and turns one registered byte into up to two results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jsfe_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               step_en,
  input  logic [7:0]         byte_q,
  input  logic               eot_q,
  input  logic [11:0]        capacity,
  output jsfe_pkg::step_out_t step_out
);
  import jsfe_pkg::*;

  typedef enum logic [5:0] {
    PH_SEARCH = 6'b000001,
    PH_SKIP   = 6'b000010,
    PH_COPY   = 6'b000100,
    PH_ESC    = 6'b001000,
    PH_HEX    = 6'b010000,
    PH_DONE   = 6'b100000
  } phase_t;

  phase_t      phase, phase_next;
  logic [3:0]  key_match_len, key_match_len_next;
  logic [2:0]  hex_skip_left, hex_skip_left_next;
  logic [11:0] chars_written, chars_written_next;
  logic [1:0]  cnt;
  result_t     res [2];

  always_comb begin
    phase_next         = phase;
    key_match_len_next = key_match_len;
    hex_skip_left_next = hex_skip_left;
    chars_written_next = chars_written;
    cnt                = 2'd0;
    res[0]             = '0;
    res[1]             = '0;
    for (int p = 0; p < 2; p++) begin
      if (p == 0 && byte_q != 8'h00) begin
        unique case (phase_next)
          PH_SEARCH: begin
            if (byte_q == key_byte(key_match_len_next)) begin
              if (key_match_len_next == 4'(KEY_LEN - 1)) begin
                key_match_len_next = 4'd0;
                phase_next         = PH_SKIP;
              end else begin
                key_match_len_next = key_match_len_next + 4'd1;
              end
            end else begin
              key_match_len_next = (byte_q == CH_QUOTE) ? 4'd1 : 4'd0;
            end
          end
          PH_SKIP: begin
            if (byte_q == CH_QUOTE) begin
              chars_written_next = 12'd0;
              phase_next         = PH_COPY;
            end else if (byte_q != CH_SPACE && byte_q != CH_TAB && byte_q != CH_COLON &&
                         byte_q != CH_LF && byte_q != CH_CR) begin
              res[cnt[0]] = mk_res(1'b1, 8'h00, ST_NOQUOTE);
              cnt         = cnt + 2'd1;
              phase_next  = PH_DONE;
            end
          end
          PH_COPY: begin
            if (byte_q == CH_QUOTE) begin
              res[cnt[0]] = mk_res(1'b1, 8'h00, ST_OK);
              cnt         = cnt + 2'd1;
              phase_next  = PH_DONE;
            end else if (chars_written_next >= capacity) begin
              res[cnt[0]] = mk_res(1'b1, 8'h00, ST_TRUNC);
              cnt         = cnt + 2'd1;
              phase_next  = PH_DONE;
            end else if (byte_q == CH_BSLASH) begin
              phase_next = PH_ESC;
            end else begin
              res[cnt[0]]        = mk_res(1'b0, byte_q, ST_OK);
              cnt                = cnt + 2'd1;
              chars_written_next = chars_written_next + 12'd1;
            end
          end
          PH_ESC: begin
            phase_next = PH_COPY;
            priority if (byte_q == CH_N) begin
              res[cnt[0]] = mk_res(1'b0, CH_LF, ST_OK);
            end else if (byte_q == CH_T) begin
              res[cnt[0]] = mk_res(1'b0, CH_TAB, ST_OK);
            end else if (byte_q == CH_R) begin
              res[cnt[0]] = mk_res(1'b0, CH_CR, ST_OK);
            end else if (byte_q == CH_U) begin
              res[cnt[0]]        = mk_res(1'b0, CH_QMARK, ST_OK);
              hex_skip_left_next = 3'd4;
              phase_next         = PH_HEX;
            end else begin
              res[cnt[0]] = mk_res(1'b0, byte_q, ST_OK);
            end
            cnt                = cnt + 2'd1;
            chars_written_next = chars_written_next + 12'd1;
          end
          PH_HEX: begin
            if (hex_skip_left_next != 3'd0) begin
              hex_skip_left_next = hex_skip_left_next - 3'd1;
            end
            if (hex_skip_left_next == 3'd0) begin
              phase_next = PH_COPY;
            end
          end
          PH_DONE: begin
          end
          default: begin
          end
        endcase
      end else if (p == 0 || eot_q) begin
        unique case (phase_next)
          PH_SEARCH: begin
            res[cnt[0]] = mk_res(1'b1, 8'h00, ST_NOKEY);
            cnt         = cnt + 2'd1;
            phase_next  = PH_DONE;
          end
          PH_SKIP: begin
            res[cnt[0]] = mk_res(1'b1, 8'h00, ST_NOQUOTE);
            cnt         = cnt + 2'd1;
            phase_next  = PH_DONE;
          end
          PH_ESC: begin
            res[cnt[0]]        = mk_res(1'b0, CH_BSLASH, ST_OK);
            cnt                = cnt + 2'd1;
            chars_written_next = chars_written_next + 12'd1;
            res[cnt[0]]        = mk_res(1'b1, 8'h00, ST_TRUNC);
            cnt                = cnt + 2'd1;
            phase_next         = PH_DONE;
          end
          PH_COPY, PH_HEX: begin
            res[cnt[0]] = mk_res(1'b1, 8'h00, ST_TRUNC);
            cnt         = cnt + 2'd1;
            phase_next  = PH_DONE;
          end
          PH_DONE: begin
          end
          default: begin
          end
        endcase
      end
    end
    if (eot_q) begin
      phase_next         = PH_SEARCH;
      key_match_len_next = 4'd0;
      hex_skip_left_next = 3'd0;
      chars_written_next = 12'd0;
    end
    if (cnt == 2'd1) begin
      res[0].last_of_run = 1'b1;
    end else if (cnt == 2'd2) begin
      res[1].last_of_run = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SEARCH;
      key_match_len <= 4'd0;
      hex_skip_left <= 3'd0;
      chars_written <= 12'd0;
    end else if (step_en) begin
      phase         <= phase_next;
      key_match_len <= key_match_len_next;
      hex_skip_left <= hex_skip_left_next;
      chars_written <= chars_written_next;
    end
  end

  assign step_out.cnt    = cnt;
  assign step_out.res[0] = res[0];
  assign step_out.res[1] = res[1];

endmodule

### src/jsfe_result_fifo.sv
// ----------------------------------------------------------------------------
// JSON string field extractor result queue
// Four-entry queue that takes up to two results a cycle and gives one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jsfe_result_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_en,
  input  jsfe_pkg::step_out_t push,
  output logic                room,
  output logic                head_valid,
  output jsfe_pkg::result_t   head,
  input  logic                pop
);
  import jsfe_pkg::*;

  result_t               mem [RES_DEPTH];
  logic [RES_PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [RES_CNT_W-1:0]  count, count_next;
  logic [1:0]            n_push;
  logic                  pop_en;

  assign n_push     = push_en ? push.cnt : 2'd0;
  assign pop_en     = pop && (count != '0);
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];
  assign room       = (count <= RES_CNT_W'(RES_DEPTH - 2));
  assign count_next = count + RES_CNT_W'(n_push) - RES_CNT_W'(pop_en);

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      mem[wr_ptr] <= push.res[0];
    end
    if (n_push == 2'd2) begin
      mem[wr_ptr + RES_PTR_W'(1)] <= push.res[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + RES_PTR_W'(n_push);
      rd_ptr <= rd_ptr + RES_PTR_W'(pop_en);
      count  <= count_next;
    end
  end

endmodule

### src/json_string_field_extractor_unit.sv
// A byte is registered on acceptance; its results then enter the result queue.
// Throughput: one byte per cycle while each byte yields at most one result and the
// result queue has room; a byte with two results gives them one at a time on the
// single result port, which drains a four-entry result queue.
// Reset (rst, synchronous): parser back to key search, queue empty, capacity 255.
// ----------------------------------------------------------------------------
// JSON string field extractor unit
// Finds the quoted key "content" in a byte stream and emits its decoded value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module json_string_field_extractor_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // in_byte[7:0]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // char_out[7:0], status_code[9:8], zero[15:10]
  output logic        m_axis_tuser,   // is_status[0]
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import jsfe_pkg::*;

  logic       in_valid;
  logic [7:0] in_byte_q;
  logic       in_eot_q;
  logic [11:0] out_capacity;
  logic       room;
  logic       step_en;
  step_out_t  step_out;
  result_t    head;

  assign pready        = 1'b1;
  assign step_en       = in_valid && room;
  assign s_axis_tready = !in_valid || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (step_en) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_eot_q  <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_capacity <= 12'd255;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      out_capacity <= pwdata[11:0];
    end
  end

  assign prdata = paddr[2] ? 32'd0 : {20'd0, out_capacity};

  jsfe_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .step_en  (step_en),
    .byte_q   (in_byte_q),
    .eot_q    (in_eot_q),
    .capacity (out_capacity),
    .step_out (step_out)
  );

  jsfe_result_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_en    (step_en),
    .push       (step_out),
    .room       (room),
    .head_valid (m_axis_tvalid),
    .head       (head),
    .pop        (m_axis_tready)
  );

  assign m_axis_tdata = {6'd0, head.status_code, head.char_out};
  assign m_axis_tuser = head.is_status;
  assign m_axis_tlast = head.last_of_run;

endmodule

### src/jsfe_checker.sv
// ----------------------------------------------------------------------------
// JSON string field extractor checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "json_string_field_extractor_unit_macros.svh"

module jsfe_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  logic [17:0] out_word;
  logic        fields_clean;
  logic        stalled;

  assign out_word     = {m_axis_tlast, m_axis_tuser, m_axis_tdata};
  assign fields_clean = (m_axis_tdata[15:10] == 6'd0) &&
                        (m_axis_tuser ? (m_axis_tdata[7:0] == 8'd0) :
                                        (m_axis_tdata[9:8] == 2'd0));
  assign stalled      = m_axis_tvalid && !m_axis_tready;

  `JSFE_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !m_axis_tvalid)
  `JSFE_ASSERT_SAME(a_status_last, clk, rst, m_axis_tvalid && m_axis_tuser, m_axis_tlast)
  `JSFE_ASSERT_SAME(a_fields_clean, clk, rst, m_axis_tvalid, fields_clean)
  `JSFE_ASSERT_NEXT(a_stall_hold, clk, rst, stalled, m_axis_tvalid && $stable(out_word))

endmodule

bind json_string_field_extractor_unit jsfe_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
